### design/base64_stream_encoder_macros.svh
// Assertion macros shared by the encoder modules.
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define B64_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define B64_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/b64enc_pkg.sv
// Package with the shared types, constants and symbol function of the Base64 encoder.
package b64enc_pkg;

    // Field and register widths.
    localparam int BYTE_W     = 8;
    localparam int LINE_POS_W = 10;
    localparam int SYM_W      = 6;
    localparam int CFG_IDX_W  = 1;

    // The effective line length is at least four, so a position below 2**LINE_POS_W
    // has a quotient of at most LINE_POS_W - 2 bits.
    localparam int REDUCE_STEPS = LINE_POS_W - 2;
    localparam int STEP_W       = $clog2(REDUCE_STEPS);
    localparam int REDUCE_W     = LINE_POS_W + REDUCE_STEPS;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_LINES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 1'b1;

    // Register reset values.
    localparam logic                  WRAP_RESET = 1'b1;
    localparam logic [LINE_POS_W-1:0] LEN_RESET  = 10'd76;
    localparam logic [LINE_POS_W-1:0] LEN_MIN    = 10'd4;

    // Special characters.
    localparam logic [BYTE_W-1:0] CHAR_PAD = 8'h3D;
    localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;

    // One closed group handed from the front end to the character serializer.
    typedef struct packed {
        logic [3:0][SYM_W-1:0] idx;   // idx[0] is the first symbol
        logic                  pad2;  // third character is '='
        logic                  pad3;  // fourth character is '='
        logic                  lf;    // a line feed follows the group
        logic                  last;  // group ends the message
    } b64_group_t;

    // Maps a 6-bit value to its character of the standard alphabet.
    function automatic logic [BYTE_W-1:0] b64_symbol(input logic [SYM_W-1:0] v);
        logic [BYTE_W-1:0] c;
        if (v < 6'd26)
        begin
            c = 8'h41 + {2'b00, v};
        end
        else if (v < 6'd52)
        begin
            c = 8'h47 + {2'b00, v};
        end
        else if (v < 6'd62)
        begin
            c = 8'hFC + {2'b00, v};
        end
        else if (v == 6'd62)
        begin
            c = 8'h2B;
        end
        else
        begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

### design/b64_stream_if.sv
// Stream interfaces for the input bytes and the output characters.
interface b64_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       out_last;

    modport source (output valid, output out_char, output out_last, input ready);
    modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

### design/b64_front.sv
// Front end: configuration registers, byte grouping, line position and group commands.
`include "base64_stream_encoder_macros.svh"

module b64_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [b64enc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [b64enc_pkg::LINE_POS_W-1:0]    cfg_wdata,
    b64_in_if.sink                               bytes,
    output b64enc_pkg::b64_group_t               cmd,
    output logic                                 cmd_push,
    input  logic                                 cmd_full
);
    import b64enc_pkg::*;

    typedef enum logic {FR_RUN, FR_REDUCE} front_state_t;

    front_state_t            state_reg, state_next;
    logic                    wrap_reg, wrap_next;
    logic [LINE_POS_W-1:0]   len_reg, len_next;
    logic [LINE_POS_W-1:0]   pos_reg, pos_next;
    logic [1:0]              phase_reg, phase_next;
    logic [BYTE_W-1:0]       pend0_reg, pend0_next;
    logic [BYTE_W-1:0]       pend1_reg, pend1_next;
    logic [LINE_POS_W-1:0]   rem_reg, rem_next;
    logic [STEP_W-1:0]       step_reg, step_next;

    logic [LINE_POS_W-1:0]   len_eff;
    logic                    need_reduce;
    logic                    accept;
    logic                    is_p1, is_p2, closes;
    logic [BYTE_W-1:0]       b0, b1, b2;
    logic [LINE_POS_W:0]     pos_sum, pos_wrap;
    logic [LINE_POS_W-1:0]   pos_adv;
    logic [REDUCE_W-1:0]     div_shift;
    logic [LINE_POS_W-1:0]   rem_step;
    logic                    len_write;

    // Effective line length and the check that the position is below it.
    assign len_eff     = (len_reg < LEN_MIN) ? LEN_MIN : len_reg;
    assign need_reduce = pos_reg >= len_eff;
    assign len_write   = cfg_we && (cfg_index == REG_LINE_LENGTH);

    // Bytes are taken only while the position is in range and the queue has room.
    assign bytes.ready = (state_reg == FR_RUN) && !need_reduce && !cmd_full;
    assign accept      = bytes.valid && bytes.ready;

    // Group decode; a phase of three behaves as an empty group.
    assign is_p1  = (phase_reg == 2'd1);
    assign is_p2  = (phase_reg == 2'd2);
    assign closes = bytes.last_byte || is_p2;
    assign b0     = (is_p1 || is_p2) ? pend0_reg : bytes.data_byte;
    assign b1     = is_p2 ? pend1_reg : bytes.data_byte;
    assign b2     = bytes.data_byte;

    // Line position advance by one group; the position is already below len_eff.
    assign pos_sum  = {1'b0, pos_reg} + 11'd4;
    assign pos_wrap = pos_sum - {1'b0, len_eff};
    assign pos_adv  = (pos_sum >= {1'b0, len_eff}) ? pos_wrap[LINE_POS_W-1:0]
                                                   : pos_sum[LINE_POS_W-1:0];

    // One restoring step of the remainder after a shorter length was written.
    assign div_shift = REDUCE_W'(len_eff) << step_reg;
    assign rem_step  = (REDUCE_W'(rem_reg) >= div_shift)
                       ? (rem_reg - div_shift[LINE_POS_W-1:0]) : rem_reg;

    // Group command toward the serializer.
    always_comb
    begin
        cmd.idx[0] = b0[7:2];
        cmd.idx[1] = {b0[1:0], ((is_p1 || is_p2) ? b1[7:4] : 4'h0)};
        cmd.idx[2] = {b1[3:0], (is_p2 ? b2[7:6] : 2'b00)};
        cmd.idx[3] = b2[5:0];
        cmd.pad2   = !(is_p1 || is_p2);
        cmd.pad3   = !is_p2;
        cmd.lf     = wrap_reg && (pos_adv == '0);
        cmd.last   = bytes.last_byte;
    end
    assign cmd_push = accept && closes;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        wrap_next  = wrap_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        phase_next = phase_reg;
        pend0_next = pend0_reg;
        pend1_next = pend1_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WRAP_LINES:  wrap_next = cfg_wdata[0];
                REG_LINE_LENGTH: len_next  = cfg_wdata;
                default:         len_next  = len_reg;
            endcase
        end

        unique case (state_reg)
            FR_RUN:
            begin
                if (need_reduce)
                begin
                    state_next = FR_REDUCE;
                    rem_next   = pos_reg;
                    step_next  = STEP_W'(REDUCE_STEPS - 1);
                end
                else if (accept)
                begin
                    if (closes)
                    begin
                        phase_next = 2'd0;
                        pos_next   = bytes.last_byte ? '0 : pos_adv;
                    end
                    else if (is_p1)
                    begin
                        pend1_next = bytes.data_byte;
                        phase_next = 2'd2;
                    end
                    else
                    begin
                        pend0_next = bytes.data_byte;
                        phase_next = 2'd1;
                    end
                end
            end
            FR_REDUCE:
            begin
                if (len_write)
                begin
                    // A new length restarts the remainder from the stored position.
                    rem_next  = pos_reg;
                    step_next = STEP_W'(REDUCE_STEPS - 1);
                end
                else if (step_reg == '0)
                begin
                    pos_next   = rem_step;
                    state_next = FR_RUN;
                end
                else
                begin
                    rem_next  = rem_step;
                    step_next = step_reg - STEP_W'(1);
                end
            end
            default:
            begin
                state_next = FR_RUN;
            end
        endcase
    end

    // State and registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_RUN;
            wrap_reg  <= WRAP_RESET;
            len_reg   <= LEN_RESET;
            pos_reg   <= '0;
            phase_reg <= 2'd0;
            rem_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wrap_reg  <= wrap_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            step_reg  <= step_next;
        end
    end

    // Held bytes carry no reset.
    always_ff @(posedge clk)
    begin
        pend0_reg <= pend0_next;
        pend1_reg <= pend1_next;
    end

    // The single-subtract advance relies on an in-range position at every byte.
    `B64_ASSERT_NOW(a_pos_in_range, accept, pos_reg < len_eff,
                    "line position out of range at accept")
    // The end of a message returns the position and phase to zero.
    `B64_ASSERT_NEXT(a_clear_after_last, accept && bytes.last_byte,
                     (pos_reg == '0) && (phase_reg == 2'd0), "state not cleared after last byte")

endmodule

### design/b64_cmd_fifo.sv
// Two-entry queue of group commands between the front end and the serializer.
module b64_cmd_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  b64enc_pkg::b64_group_t  push_data,
    output logic                    full,
    input  logic                    pop,
    output b64enc_pkg::b64_group_t  pop_data,
    output logic                    empty
);
    import b64enc_pkg::*;

    b64_group_t  entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/b64_back.sv
// Serializer: turns group commands into characters behind an output register.
`include "base64_stream_encoder_macros.svh"

module b64_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  b64enc_pkg::b64_group_t  cmd,
    input  logic                    cmd_empty,
    output logic                    cmd_pop,
    b64_out_if.source               chars
);
    import b64enc_pkg::*;

    b64_group_t         cur_reg, cur_next;
    logic               cur_valid_reg, cur_valid_next;
    logic [2:0]         slot_reg, slot_next;
    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  out_char_reg;
    logic               out_last_reg;

    logic               advance, at_final, load;
    logic [2:0]         final_slot;
    logic [BYTE_W-1:0]  char_sel;

    // A character moves into the output register when it is empty or being taken.
    assign advance    = cur_valid_reg && (!out_valid_reg || chars.ready);
    assign final_slot = cur_reg.lf ? 3'd4 : 3'd3;
    assign at_final   = (slot_reg == final_slot);
    assign load       = !cur_valid_reg || (advance && at_final);
    assign cmd_pop    = load && !cmd_empty;

    // Character of the current slot.
    always_comb
    begin
        unique case (slot_reg)
            3'd0:    char_sel = b64_symbol(cur_reg.idx[0]);
            3'd1:    char_sel = b64_symbol(cur_reg.idx[1]);
            3'd2:    char_sel = cur_reg.pad2 ? CHAR_PAD : b64_symbol(cur_reg.idx[2]);
            3'd3:    char_sel = cur_reg.pad3 ? CHAR_PAD : b64_symbol(cur_reg.idx[3]);
            default: char_sel = CHAR_LF;
        endcase
    end

    // Next values of the group holder and output flags.
    always_comb
    begin
        cur_next       = load ? cmd : cur_reg;
        cur_valid_next = load ? !cmd_empty : cur_valid_reg;
        slot_next      = load ? 3'd0 : (advance ? slot_reg + 3'd1 : slot_reg);
        out_valid_next = advance ? 1'b1 : (chars.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            slot_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (advance)
        begin
            out_char_reg <= char_sel;
            out_last_reg <= cur_reg.last && at_final;
        end
    end

    assign chars.valid    = out_valid_reg;
    assign chars.out_char = out_char_reg;
    assign chars.out_last = out_last_reg;

    // The final character of a closing group carries the end flag.
    `B64_ASSERT_NEXT(a_last_on_final, advance && at_final && cur_reg.last, chars.valid && chars.out_last, "end flag missing on final character")
    // The slot counter never runs past the line feed.
    `B64_ASSERT_NOW(a_slot_range, cur_valid_reg, slot_reg <= final_slot, "slot counter past final character")

endmodule

### design/base64_stream_encoder.sv
// Top level of the Base64 stream encoder.
// Usage:
//   bytes: input channel, one byte per transaction, last_byte marks the message end.
//   chars: output channel, one character per transaction, out_last on the final one.
//   cfg_we/cfg_index/cfg_wdata: index 0 is wrap_lines (bit 0), index 1 is line_length.
// The front end takes one byte per cycle while the queue has room and it is not
// reducing, and closes a group on every third byte or on the last byte; the serializer
// sends one character per cycle while the receiver is ready, four per group, five when
// a line feed follows. Sustained intake is thus set by the serializer's single output
// character per cycle. A group passes from the queue into the serializer's group holder,
// and each of its characters then into the output register.
// A two-entry group queue sits between the two sides, so bytes keep flowing while
// the receiver stalls until the queue fills; then bytes.ready drops.
// When a write leaves the line position at or above the new line length, the front
// end reduces it modulo that length in restoring steps before taking the next byte.
// Reset clears the group, the line position and all queued work, and loads
// wrap_lines = 1 and line_length = 76.
module base64_stream_encoder (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [b64enc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [b64enc_pkg::LINE_POS_W-1:0]    cfg_wdata,
    b64_in_if.sink                               bytes,
    b64_out_if.source                            chars
);
    import b64enc_pkg::*;

    b64_group_t  front_cmd;
    b64_group_t  queue_cmd;
    logic        cmd_push;
    logic        cmd_full;
    logic        cmd_pop;
    logic        cmd_empty;

    // Byte grouping and line position.
    b64_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .bytes     (bytes),
        .cmd       (front_cmd),
        .cmd_push  (cmd_push),
        .cmd_full  (cmd_full)
    );

    // Group queue.
    b64_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (front_cmd),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (queue_cmd),
        .empty     (cmd_empty)
    );

    // Character serializer.
    b64_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (queue_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .chars     (chars)
    );

endmodule
